// ===== hw/rtl/ldf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants for the length-prefixed byte deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    typedef enum logic [2:0] {
        PH_LEN_LO  = 3'b001,
        PH_LEN_HI  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef enum logic {
        REQ_DATA  = 1'b0,
        REQ_ERROR = 1'b1
    } req_t;

    typedef struct packed {
        req_t              req_type;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic              is_last;
        logic              aborted;
    } result_t;

endpackage

// ===== hw/rtl/ldf_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_in_stage
// Input register: holds one received item until the core consumes it.
// ----------------------------------------------------------------------------
module ldf_in_stage
    import ldf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  out_free,
    output logic  adv,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign adv      = valid_reg && out_free;
    assign s_tready = !valid_reg || out_free;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hw/rtl/ldf_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_core
// Frame state and per-item decode: length bytes, payload, error abort.
// ----------------------------------------------------------------------------
module ldf_core
    import ldf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  item_t   item,
    output result_t res
);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W-1:0] full_len;
    logic             last;

    assign pos_inc  = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign last     = pos_inc >= {1'b0, len_reg};
    assign full_len = {item.rx_byte, len_reg[BYTE_W-1:0]};

    always_comb
    begin
        phase_next       = phase_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        res              = '0;
        res.payload_byte = item.rx_byte;
        res.byte_index   = pos_reg;
        res.frame_length = len_reg;
        if (adv)
        begin
            if (item.req_type == REQ_ERROR)
            begin
                res.payload_byte = '0;
                res.aborted      = 1'b1;
                case (phase_reg)
                    PH_LEN_HI:
                    begin
                        res.valid        = 1'b1;
                        res.byte_index   = '0;
                        res.frame_length = '0;
                    end
                    PH_PAYLOAD:
                    begin
                        res.valid = 1'b1;
                    end
                    default:
                    begin
                        res.valid = 1'b0;
                    end
                endcase
                phase_next = PH_LEN_LO;
                len_next   = '0;
                pos_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_HI:
                    begin
                        len_next   = full_len;
                        pos_next   = '0;
                        phase_next = (full_len != '0) ? PH_PAYLOAD : PH_LEN_LO;
                    end
                    PH_PAYLOAD:
                    begin
                        res.valid   = 1'b1;
                        res.is_last = last;
                        if (last)
                        begin
                            phase_next = PH_LEN_LO;
                            len_next   = '0;
                            pos_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc[LEN_W-1:0];
                        end
                    end
                    default:
                    begin
                        len_next   = {{(LEN_W-BYTE_W){1'b0}}, item.rx_byte};
                        pos_next   = '0;
                        phase_next = PH_LEN_HI;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_LO;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    // frame ends on last byte or abort
    a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.is_last || res.aborted)) |=> (phase_reg == PH_LEN_LO))
        else $error("phase not idle after frame end");

    // payload phase always has bytes left to deliver
    a_pos_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (pos_reg < len_reg))
        else $error("payload position reached frame length");

    // length bytes never produce a transfer
    a_len_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && item.req_type == REQ_DATA && phase_reg != PH_PAYLOAD) |-> !res.valid)
        else $error("result from a length byte");

endmodule

// ===== hw/rtl/ldf_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_out_stage
// Result register towards the master side.
// ----------------------------------------------------------------------------
module ldf_out_stage
    import ldf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign out_free = !valid_reg || m_tready;
    assign load     = adv && res.valid;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/length_prefix_byte_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_byte_deframer_top
// Deframer for a byte stream of 16-bit little-endian length-prefixed frames.
// ----------------------------------------------------------------------------
// One received byte (or a connection-error marker) is taken per cycle and each
// payload byte leaves as one transfer with its index, the frame length and
// tlast on the frame's final byte. An input transfer passes an input register,
// one pass of state logic and a result register on its way to the output.
// Throughput is one item per cycle; the only stall comes from m_tready, which
// reaches s_tready combinationally. Zero-length frames are dropped. An error
// mid-frame yields one transfer with tuser set (aborted), zero data and the
// count of bytes already delivered; tlast is low on it.
module length_prefix_byte_deframer_top
    import ldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [23:8] byte_index,
                                   // [39:24] frame_length
    output logic        m_tlast,   // is_last
    output logic [0:0]  m_tuser    // [0] aborted
);

    item_t   s_item;
    item_t   item;
    result_t res;
    result_t m_res;
    logic    adv;
    logic    out_free;

    assign s_item.req_type = req_t'(s_tuser[0]);
    assign s_item.rx_byte  = s_tdata;

    ldf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .out_free (out_free),
        .adv      (adv),
        .item     (item)
    );

    ldf_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item),
        .res   (res)
    );

    ldf_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata    = {m_res.frame_length, m_res.byte_index, m_res.payload_byte};
    assign m_tlast    = m_res.is_last;
    assign m_tuser[0] = m_res.aborted;

endmodule
